[rtl/i2cbb_pkg.sv]
// Shared constants and types for the bit-banged I2C master.
package i2cbb_pkg;

   localparam int BYTE_BITS = 8;
   localparam int BIT_IDX_W = $clog2(BYTE_BITS);
   localparam int CMD_W = 3;
   localparam int TIMEOUT_W = 8;
   localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RESET = 8'd250;

   localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

   typedef enum logic [18:0] {
      ST_IDLE  = 19'h00001,
      ST_S1    = 19'h00002,
      ST_S2    = 19'h00004,
      ST_S3    = 19'h00008,
      ST_P1    = 19'h00010,
      ST_P2    = 19'h00020,
      ST_P3    = 19'h00040,
      ST_WLO   = 19'h00080,
      ST_WHI   = 19'h00100,
      ST_AREL  = 19'h00200,
      ST_AHI   = 19'h00400,
      ST_AWAIT = 19'h00800,
      ST_AEND  = 19'h01000,
      ST_RHI   = 19'h02000,
      ST_RLO   = 19'h04000,
      ST_K1    = 19'h08000,
      ST_K2    = 19'h10000,
      ST_K3    = 19'h20000,
      ST_K4    = 19'h40000
   } step_type;

endpackage

[rtl/i2cbb_req_if.sv]
// Request channel: one bus timing tick with optional command and sampled SDA.
interface i2cbb_req_if;
   logic                            valid;
   logic                            ready;
   logic [i2cbb_pkg::CMD_W-1:0]     cmd;
   logic [i2cbb_pkg::BYTE_BITS-1:0] write_byte;
   logic                            send_nack;
   logic                            sda_in;

   modport source (output valid, cmd, write_byte, send_nack, sda_in, input ready);
   modport sink (input valid, cmd, write_byte, send_nack, sda_in, output ready);
endinterface

[rtl/i2cbb_rsp_if.sv]
// Response channel: driven line levels and status for one tick.
interface i2cbb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            scl_out;
   logic                            sda_out;
   logic                            busy_res;
   logic                            done_res;
   logic [i2cbb_pkg::BYTE_BITS-1:0] read_byte;
   logic                            ack_error;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, read_byte, ack_error,
                   input ready);
   modport sink (input valid, scl_out, sda_out, busy_res, done_res, read_byte, ack_error,
                 output ready);
endinterface

[rtl/i2cbb_csr_if.sv]
// Configuration write channel carrying the ack timeout register.
interface i2cbb_csr_if;
   logic                            valid;
   logic                            ready;
   logic [i2cbb_pkg::TIMEOUT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[rtl/i2c_bitbang_master.sv]
// Top level of the bit-banged I2C master: tick sequencer and result register.
// Latency: a result appears in the cycle after its request transaction is accepted.
// Throughput: one request transaction per cycle; the result register stalls input
// only while a held result is not taken.
// Reset: sequencer idle, SCL and SDA released high, read byte and error cleared,
// ack timeout 250 ticks, no result pending.
module i2c_bitbang_master (
   input logic         clock,
   input logic         reset,
   i2cbb_req_if.sink   req_port,
   i2cbb_rsp_if.source rsp_port,
   i2cbb_csr_if.sink   csr_port
);
   import i2cbb_pkg::*;

   step_type               step_ff, step_in, step_cur;
   logic [BIT_IDX_W-1:0]   bit_idx_ff, bit_idx_in;
   logic [BYTE_BITS-1:0]   shift_ff, shift_in;
   logic [TIMEOUT_W-1:0]   wait_cnt_ff, wait_cnt_in;
   logic                   nack_ff, nack_in;
   logic                   err_ff, err_in;
   logic                   scl_ff, scl_in;
   logic                   sda_ff, sda_in_lv;
   logic [BYTE_BITS-1:0]   last_rd_ff, last_rd_in;
   logic [TIMEOUT_W-1:0]   timeout_ff;
   logic                   busy, done;
   logic                   accept;
   logic                   rsp_valid_ff;
   logic                   rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff, rsp_err_ff;
   logic [BYTE_BITS-1:0]   rsp_rd_ff;
   logic                   last_bit;

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;
   assign last_bit = (bit_idx_ff == BIT_IDX_W'(BYTE_BITS - 1));

   always_comb begin
      step_cur    = step_ff;
      bit_idx_in  = bit_idx_ff;
      shift_in    = shift_ff;
      wait_cnt_in = wait_cnt_ff;
      nack_in     = nack_ff;
      err_in      = err_ff;
      scl_in      = scl_ff;
      sda_in_lv   = sda_ff;
      last_rd_in  = last_rd_ff;
      done        = 1'b0;

      if (step_ff == ST_IDLE) begin
         case (req_port.cmd)
            CMD_START: step_cur = ST_S1;
            CMD_STOP:  step_cur = ST_P1;
            CMD_WRITE: begin
               shift_in    = req_port.write_byte;
               bit_idx_in  = '0;
               wait_cnt_in = '0;
               err_in      = 1'b0;
               step_cur    = ST_WLO;
            end
            CMD_READ: begin
               nack_in    = req_port.send_nack;
               shift_in   = '0;
               bit_idx_in = '0;
               step_cur   = ST_RHI;
            end
            default: step_cur = ST_IDLE;
         endcase
      end

      busy    = (step_cur != ST_IDLE);
      step_in = ST_IDLE;

      case (step_cur)
         ST_IDLE: step_in = ST_IDLE;
         ST_S1: begin
            scl_in    = 1'b1;
            sda_in_lv = 1'b1;
            step_in   = ST_S2;
         end
         ST_S2: begin
            sda_in_lv = 1'b0;
            step_in   = ST_S3;
         end
         ST_S3: begin
            scl_in = 1'b0;
            done   = 1'b1;
         end
         ST_P1: begin
            sda_in_lv = 1'b0;
            step_in   = ST_P2;
         end
         ST_P2: begin
            scl_in  = 1'b1;
            step_in = ST_P3;
         end
         ST_P3: begin
            sda_in_lv = 1'b1;
            done      = 1'b1;
         end
         ST_WLO: begin
            scl_in    = 1'b0;
            sda_in_lv = shift_in[BYTE_BITS-1];
            step_in   = ST_WHI;
         end
         ST_WHI: begin
            scl_in   = 1'b1;
            shift_in = {shift_ff[BYTE_BITS-2:0], 1'b0};
            if (last_bit) begin
               bit_idx_in = '0;
               step_in    = ST_AREL;
            end else begin
               bit_idx_in = bit_idx_ff + 1'b1;
               step_in    = ST_WLO;
            end
         end
         ST_AREL: begin
            scl_in    = 1'b0;
            sda_in_lv = 1'b1;
            step_in   = ST_AHI;
         end
         ST_AHI: begin
            scl_in      = 1'b1;
            wait_cnt_in = '0;
            step_in     = ST_AWAIT;
         end
         ST_AWAIT: begin
            if (!req_port.sda_in) begin
               step_in = ST_AEND;
            end else if (wait_cnt_ff >= timeout_ff) begin
               err_in  = 1'b1;
               step_in = ST_P1;
            end else begin
               wait_cnt_in = wait_cnt_ff + 1'b1;
               step_in     = ST_AWAIT;
            end
         end
         ST_AEND: begin
            scl_in = 1'b0;
            done   = 1'b1;
         end
         ST_RHI: begin
            scl_in    = 1'b1;
            sda_in_lv = 1'b1;
            shift_in  = {shift_in[BYTE_BITS-2:0], req_port.sda_in};
            step_in   = ST_RLO;
         end
         ST_RLO: begin
            scl_in = 1'b0;
            if (last_bit) begin
               bit_idx_in = '0;
               last_rd_in = shift_ff;
               step_in    = ST_K1;
            end else begin
               bit_idx_in = bit_idx_ff + 1'b1;
               step_in    = ST_RHI;
            end
         end
         ST_K1: begin
            sda_in_lv = nack_ff;
            step_in   = ST_K2;
         end
         ST_K2: begin
            scl_in  = 1'b1;
            step_in = ST_K3;
         end
         ST_K3: begin
            scl_in = 1'b0;
            if (nack_ff) begin
               done = 1'b1;
            end else begin
               step_in = ST_K4;
            end
         end
         ST_K4: begin
            sda_in_lv = 1'b1;
            done      = 1'b1;
         end
         default: step_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= ST_IDLE;
         bit_idx_ff  <= '0;
         shift_ff    <= '0;
         wait_cnt_ff <= '0;
         nack_ff     <= 1'b0;
         err_ff      <= 1'b0;
         scl_ff      <= 1'b1;
         sda_ff      <= 1'b1;
         last_rd_ff  <= '0;
      end else if (accept) begin
         step_ff     <= step_in;
         bit_idx_ff  <= bit_idx_in;
         shift_ff    <= shift_in;
         wait_cnt_ff <= wait_cnt_in;
         nack_ff     <= nack_in;
         err_ff      <= err_in;
         scl_ff      <= scl_in;
         sda_ff      <= sda_in_lv;
         last_rd_ff  <= last_rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= ACK_TIMEOUT_RESET;
      end else if (csr_port.valid) begin
         timeout_ff <= csr_port.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_scl_ff  <= scl_in;
         rsp_sda_ff  <= sda_in_lv;
         rsp_busy_ff <= busy;
         rsp_done_ff <= done;
         rsp_rd_ff   <= last_rd_in;
         rsp_err_ff  <= err_in;
      end
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.scl_out   = rsp_scl_ff;
   assign rsp_port.sda_out   = rsp_sda_ff;
   assign rsp_port.busy_res  = rsp_busy_ff;
   assign rsp_port.done_res  = rsp_done_ff;
   assign rsp_port.read_byte = rsp_rd_ff;
   assign rsp_port.ack_error = rsp_err_ff;

endmodule

[rtl/i2cbb_checker.sv]
// Port-level checks for the bit-banged I2C master, bound to the top level.
module i2cbb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_scl,
   input logic                            rsp_sda,
   input logic                            rsp_busy,
   input logic                            rsp_done,
   input logic [i2cbb_pkg::BYTE_BITS-1:0] rsp_read_byte,
   input logic                            rsp_err
);
   import i2cbb_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted transaction produced no result");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done) |-> rsp_busy)
      else $error("done flagged outside a busy sequence");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_scl) && $stable(rsp_sda)
         && $stable(rsp_busy) && $stable(rsp_done) && $stable(rsp_read_byte)
         && $stable(rsp_err)))
      else $error("stalled result changed");

endmodule

bind i2c_bitbang_master i2cbb_checker u_i2cbb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_port.valid),
   .req_ready     (req_port.ready),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .rsp_scl       (rsp_port.scl_out),
   .rsp_sda       (rsp_port.sda_out),
   .rsp_busy      (rsp_port.busy_res),
   .rsp_done      (rsp_port.done_res),
   .rsp_read_byte (rsp_port.read_byte),
   .rsp_err       (rsp_port.ack_error)
);

[dv/testbench.sv]
// Self-checking testbench for the bit-banged I2C master: tick stimulus, line prediction, checks.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cbb_pkg::*;

   localparam int PERIOD = 20;
   localparam int QUIET_LIMIT = 3000;
   localparam int ACK_NEVER = 1_000_000;

   typedef struct packed {
      logic                 scl;
      logic                 sda;
      logic                 busy;
      logic                 done;
      logic [BYTE_BITS-1:0] rbyte;
      logic                 err;
   } line_tick_type;

   logic clock = 1'b0;
   logic reset;

   i2cbb_req_if req_if();
   i2cbb_rsp_if rsp_if();
   i2cbb_csr_if csr_if();

   i2c_bitbang_master dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   always #(PERIOD / 2) clock = ~clock;

   // predicted block state
   step_type               bus_step = ST_IDLE;
   logic [BIT_IDX_W-1:0]   bit_count = '0;
   logic [BYTE_BITS-1:0]   shifter = '0;
   logic [TIMEOUT_W-1:0]   poll_count = '0;
   logic [TIMEOUT_W-1:0]   ack_limit = ACK_TIMEOUT_RESET;
   logic                   read_nack = 1'b0;
   logic                   ack_missing = 1'b0;
   logic                   scl_lv = 1'b1;
   logic                   sda_lv = 1'b1;
   logic [BYTE_BITS-1:0]   last_rx = '0;

   line_tick_type expected_ticks[$];
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_request = 0;
   int fail_count = 0;
   int ticks_sent = 0;
   int results_checked = 0;
   int sequences_done = 0;
   int ack_timeouts_seen = 0;
   int settings_written = 0;
   int quiet_cycles = 0;

   function automatic line_tick_type predict_line_tick(input logic [CMD_W-1:0] cmd,
                                                       input logic [BYTE_BITS-1:0] wbyte,
                                                       input logic nack, input logic sda);
      line_tick_type r;
      r = '0;
      if (bus_step == ST_IDLE) begin
         case (cmd)
            CMD_START: bus_step = ST_S1;
            CMD_STOP: bus_step = ST_P1;
            CMD_WRITE: begin
               shifter = wbyte;
               bit_count = '0;
               poll_count = '0;
               ack_missing = 1'b0;
               bus_step = ST_WLO;
            end
            CMD_READ: begin
               read_nack = nack;
               shifter = '0;
               bit_count = '0;
               bus_step = ST_RHI;
            end
            default: ;
         endcase
      end
      r.busy = (bus_step != ST_IDLE);
      case (bus_step)
         ST_S1: begin
            scl_lv = 1'b1;
            sda_lv = 1'b1;
            bus_step = ST_S2;
         end
         ST_S2: begin
            sda_lv = 1'b0;
            bus_step = ST_S3;
         end
         ST_S3: begin
            scl_lv = 1'b0;
            r.done = 1'b1;
            bus_step = ST_IDLE;
         end
         ST_P1: begin
            sda_lv = 1'b0;
            bus_step = ST_P2;
         end
         ST_P2: begin
            scl_lv = 1'b1;
            bus_step = ST_P3;
         end
         ST_P3: begin
            sda_lv = 1'b1;
            r.done = 1'b1;
            bus_step = ST_IDLE;
         end
         ST_WLO: begin
            scl_lv = 1'b0;
            sda_lv = shifter[BYTE_BITS-1];
            bus_step = ST_WHI;
         end
         ST_WHI: begin
            scl_lv = 1'b1;
            shifter = shifter << 1;
            if (bit_count == BIT_IDX_W'(BYTE_BITS - 1)) begin
               bit_count = '0;
               bus_step = ST_AREL;
            end else begin
               bit_count = bit_count + 1'b1;
               bus_step = ST_WLO;
            end
         end
         ST_AREL: begin
            scl_lv = 1'b0;
            sda_lv = 1'b1;
            bus_step = ST_AHI;
         end
         ST_AHI: begin
            scl_lv = 1'b1;
            poll_count = '0;
            bus_step = ST_AWAIT;
         end
         ST_AWAIT: begin
            if (!sda) begin
               bus_step = ST_AEND;
            end else if (poll_count >= ack_limit) begin
               ack_missing = 1'b1;
               ack_timeouts_seen++;
               bus_step = ST_P1;
            end else begin
               poll_count = poll_count + 1'b1;
            end
         end
         ST_AEND: begin
            scl_lv = 1'b0;
            r.done = 1'b1;
            bus_step = ST_IDLE;
         end
         ST_RHI: begin
            scl_lv = 1'b1;
            sda_lv = 1'b1;
            shifter = {shifter[BYTE_BITS-2:0], sda};
            bus_step = ST_RLO;
         end
         ST_RLO: begin
            scl_lv = 1'b0;
            if (bit_count == BIT_IDX_W'(BYTE_BITS - 1)) begin
               bit_count = '0;
               last_rx = shifter;
               bus_step = ST_K1;
            end else begin
               bit_count = bit_count + 1'b1;
               bus_step = ST_RHI;
            end
         end
         ST_K1: begin
            sda_lv = read_nack;
            bus_step = ST_K2;
         end
         ST_K2: begin
            scl_lv = 1'b1;
            bus_step = ST_K3;
         end
         ST_K3: begin
            scl_lv = 1'b0;
            if (read_nack) begin
               r.done = 1'b1;
               bus_step = ST_IDLE;
            end else begin
               bus_step = ST_K4;
            end
         end
         ST_K4: begin
            sda_lv = 1'b1;
            r.done = 1'b1;
            bus_step = ST_IDLE;
         end
         default: bus_step = ST_IDLE;
      endcase
      if (r.done) sequences_done++;
      r.scl = scl_lv;
      r.sda = sda_lv;
      r.rbyte = last_rx;
      r.err = ack_missing;
      return r;
   endfunction

   task automatic send_tick(input logic [CMD_W-1:0] cmd, input logic [BYTE_BITS-1:0] wbyte,
                            input logic nack, input logic sda);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd <= cmd;
      req_if.write_byte <= wbyte;
      req_if.send_nack <= nack;
      req_if.sda_in <= sda;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      expected_ticks.push_back(predict_line_tick(cmd, wbyte, nack, sda));
      ticks_sent++;
   endtask

   // one command tick, then ticks until the sequence has finished
   task automatic run_bus_sequence(input logic [CMD_W-1:0] cmd,
                                   input logic [BYTE_BITS-1:0] wbyte, input logic nack,
                                   input logic [BYTE_BITS-1:0] rx_bits, input int ack_wait);
      int rx_used;
      int polls;
      logic sda;
      logic [CMD_W-1:0] extra_cmd;
      rx_used = 0;
      polls = 0;
      if (bus_step == ST_IDLE && cmd == CMD_READ) begin
         sda = rx_bits[BYTE_BITS-1];
         rx_used = 1;
      end else begin
         sda = 1'($urandom_range(1));
      end
      send_tick(cmd, wbyte, nack, sda);
      while (bus_step != ST_IDLE) begin
         if (bus_step == ST_RHI) begin
            sda = rx_bits[BYTE_BITS-1-rx_used];
            rx_used++;
         end else if (bus_step == ST_AWAIT) begin
            sda = (polls >= ack_wait) ? 1'b0 : 1'b1;
            polls++;
         end else begin
            sda = 1'($urandom_range(1));
         end
         extra_cmd = ($urandom_range(3) == 0) ? CMD_W'($urandom_range((1 << CMD_W) - 1))
                                              : CMD_NONE;
         send_tick(extra_cmd, BYTE_BITS'($urandom_range(255)), 1'($urandom_range(1)), sda);
      end
   endtask

   task automatic run_random_ticks(input int budget);
      int start_count;
      int pick;
      int ack_wait;
      logic [CMD_W-1:0] cmd;
      start_count = ticks_sent;
      while (ticks_sent - start_count < budget) begin
         pick = $urandom_range(99);
         if (pick < 15) cmd = CMD_START;
         else if (pick < 30) cmd = CMD_STOP;
         else if (pick < 58) cmd = CMD_WRITE;
         else if (pick < 85) cmd = CMD_READ;
         else if (pick < 93) cmd = CMD_NONE;
         else cmd = CMD_W'($urandom_range(CMD_READ + 1, (1 << CMD_W) - 1));
         pick = $urandom_range(99);
         if (pick < 4) ack_wait = ACK_NEVER;
         else if (pick < 10) ack_wait = ack_limit;
         else if (pick < 16) ack_wait = ack_limit + 1;
         else ack_wait = $urandom_range(3);
         run_bus_sequence(cmd, BYTE_BITS'($urandom_range(255)), 1'($urandom_range(1)),
                          BYTE_BITS'($urandom_range(255)), ack_wait);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_ticks.size() != 0) @(negedge clock);
   endtask

   task automatic write_ack_timeout(input logic [TIMEOUT_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      ack_limit = value;
      settings_written++;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_ack_timeout('0);
      run_bus_sequence(CMD_NONE, 8'h00, 1'b0, 8'h00, 0);
      run_bus_sequence(CMD_NONE, 8'hFF, 1'b1, 8'hFF, 0);
      for (int c = CMD_READ + 1; c < (1 << CMD_W); c++) begin
         run_bus_sequence(CMD_W'(c), 8'hFF, 1'b1, 8'h00, 0);
      end
      run_bus_sequence(CMD_START, 8'h00, 1'b0, 8'h00, 0);
      run_bus_sequence(CMD_WRITE, 8'h00, 1'b0, 8'h00, 0);
      run_bus_sequence(CMD_WRITE, 8'hFF, 1'b0, 8'h00, ACK_NEVER);
      wait_idle();
      write_ack_timeout(TIMEOUT_W'(3));
      run_bus_sequence(CMD_START, 8'h00, 1'b0, 8'h00, 0);
      run_bus_sequence(CMD_WRITE, 8'hA5, 1'b0, 8'h00, 3);
      run_bus_sequence(CMD_WRITE, 8'h5A, 1'b0, 8'h00, 4);
      run_bus_sequence(CMD_READ, 8'h00, 1'b0, 8'hFF, 0);
      run_bus_sequence(CMD_READ, 8'hFF, 1'b1, 8'h00, 0);
      run_bus_sequence(CMD_READ, 8'h00, 1'b0, 8'h96, 0);
      run_bus_sequence(CMD_STOP, 8'h00, 1'b0, 8'h00, 0);
      run_bus_sequence(CMD_STOP, 8'h00, 1'b0, 8'h00, 0);
      run_bus_sequence(CMD_WRITE, 8'h3C, 1'b0, 8'h00, 1);
      wait_idle();
   endtask

   task automatic test_no_idle();
      write_ack_timeout('1);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random_ticks(280);
      wait_idle();
   endtask

   task automatic test_sender_idle();
      write_ack_timeout(TIMEOUT_W'(1));
      send_idle_pct = 81;
      rsp_stall_pct = 0;
      run_random_ticks(170);
      wait_idle();
   endtask

   task automatic test_receiver_stall();
      write_ack_timeout(ACK_TIMEOUT_RESET);
      send_idle_pct = 0;
      rsp_stall_pct = 81;
      run_random_ticks(170);
      wait_idle();
   endtask

   task automatic test_both_idle();
      write_ack_timeout(TIMEOUT_W'($urandom_range(2, 20)));
      send_idle_pct = 30;
      rsp_stall_pct = 30;
      run_random_ticks(170);
      wait_idle();
   endtask

   task automatic test_backpressure();
      write_ack_timeout(TIMEOUT_W'(5));
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request = 300;
      run_random_ticks(80);
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.cmd = CMD_NONE;
      req_if.write_byte = '0;
      req_if.send_nack = 1'b0;
      req_if.sda_in = 1'b1;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_no_idle();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_backpressure();
      wait_idle();
      repeat (4) @(posedge clock);
      $display("Covered %0d bus ticks, %0d finished sequences, %0d ack timeouts,",
               ticks_sent, sequences_done, ack_timeouts_seen);
      $display("%0d timeout settings and %0d checked results.",
               settings_written, results_checked);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // result side: random stalls plus long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      line_tick_type got;
      line_tick_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = {rsp_if.scl_out, rsp_if.sda_out, rsp_if.busy_res, rsp_if.done_res,
                rsp_if.read_byte, rsp_if.ack_error};
         if (expected_ticks.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("unexpected result transaction: scl %b sda %b busy %b done %b rd %h err %b",
                        got.scl, got.sda, got.busy, got.done, got.rbyte, got.err);
            end
         end else begin
            want = expected_ticks.pop_front();
            results_checked++;
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("result %0d mismatch: expected scl %b sda %b busy %b done %b rd %h err %b",
                           results_checked, want.scl, want.sda, want.busy, want.done,
                           want.rbyte, want.err);
                  $display("   got scl %b sda %b busy %b done %b rd %h err %b",
                           got.scl, got.sda, got.busy, got.done, got.rbyte, got.err);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule
